@@ design/pedal_swept_wah_biquad_assert.svh @@
// Assertion macros for the wah filter block.
`ifndef PEDAL_SWEPT_WAH_BIQUAD_ASSERT_SVH
`define PEDAL_SWEPT_WAH_BIQUAD_ASSERT_SVH
// Check that a condition implies a consequence at the same edge.
`define PSW_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence at the next edge.
`define PSW_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);
`endif

@@ design/psw_pkg.sv @@
// Package with shared types and constants of the wah filter block.
`timescale 1ns / 1ps
package psw_pkg;
  localparam int SampleBitsDef = 24;
  localparam int CoefBitsDef   = 32;
  localparam int RegBits       = 32;
  localparam int IdxBits       = 3;
  localparam int QBits         = 17;
  localparam logic [16:0] GainQ16 = 17'd55706;
  localparam logic [16:0] OneQ16  = 17'd65536;

  typedef enum logic [IdxBits-1:0] {
    REG_B0 = 3'd0, REG_B1 = 3'd1, REG_B2 = 3'd2, REG_D0 = 3'd3,
    REG_D1 = 3'd4, REG_SLOPE = 3'd5, REG_BAL = 3'd6, REG_PMAX = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GAIN, ST_DIV1, ST_DIV2, ST_MAC, ST_MIX, ST_OUT
  } state_e;

  // Start/done pair between the sequencer and a serial unit.
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;
endpackage

@@ design/psw_sermul.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
`timescale 1ns / 1ps
module psw_sermul #(
  parameter int ABits = 32,
  parameter int BBits = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [ABits-1:0]         a_i,
  input  logic signed [BBits-1:0]         b_i,
  output logic                            done_o,
  output logic signed [ABits+BBits-1:0]   p_o
);
  import psw_pkg::*;
  localparam int CntBits = $clog2(BBits + 1);
  localparam int PBits   = ABits + BBits;

  logic                 busy_q, busy_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [BBits-1:0]     b_q, b_d;
  logic signed [PBits-1:0] a_q, a_d, acc_q, acc_d;
  logic                 done_q, done_d;

  // Add the shifted multiplicand per bit; top bit carries negative weight.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    b_d    = b_q;
    a_d    = a_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      b_d    = b_i;
      a_d    = PBits'(a_i);
      acc_d  = '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        if (cnt_q == CntBits'(BBits - 1)) acc_d = acc_q - a_q;
        else acc_d = acc_q + a_q;
      end
      a_d = a_q <<< 1;
      b_d = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(BBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q   <= b_d;
    a_q   <= a_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign p_o    = acc_q;
endmodule

@@ design/psw_serdiv.sv @@
// Restoring divider: one quotient bit per cycle, truncation toward zero.
`timescale 1ns / 1ps
module psw_serdiv #(
  parameter int NBits = 64,
  parameter int DBits = 34
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [NBits-1:0]  num_i,
  input  logic signed [DBits-1:0]  den_i,
  output logic                     done_o,
  output logic signed [NBits-1:0]  quo_o
);
  import psw_pkg::*;
  localparam int CntBits = $clog2(NBits + 1);

  logic               busy_q, done_q, neg_q;
  logic [CntBits-1:0] cnt_q;
  logic [NBits-1:0]   quo_q;
  logic [DBits:0]     rem_q, dmag_q;
  logic [DBits:0]     trial;
  logic [NBits-1:0]   nmag;
  logic [DBits-1:0]   dmag;

  assign nmag  = num_i[NBits-1] ? NBits'(-num_i) : NBits'(num_i);
  assign dmag  = den_i[DBits-1] ? DBits'(-den_i) : DBits'(den_i);
  assign trial = {rem_q[DBits-1:0], quo_q[NBits-1]};

  // Shift in one dividend bit, subtract the divisor where it fits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntBits'(NBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= nmag;
      rem_q  <= '0;
      dmag_q <= {1'b0, dmag};
      neg_q  <= num_i[NBits-1] ^ den_i[DBits-1];
    end else if (busy_q) begin
      if (trial >= dmag_q) begin
        rem_q <= trial - dmag_q;
        quo_q <= {quo_q[NBits-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NBits-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? NBits'(-quo_q) : NBits'(quo_q);
endmodule

@@ design/pedal_swept_wah_biquad.sv @@
// Top level of the pedal-swept wah biquad with its sequencer.
`timescale 1ns / 1ps
// Pedal-swept wah biquad. Each transaction carries one sample and a pedal
// position and yields one mixed sample. Work runs one item at a time over a
// bit-serial multiplier and a one-bit-a-step divider: take the transaction,
// form the pedal term, divide out the two feedback coefficients, run the
// five filter taps and the two mix products, then load the output register.
// A zero lead term skips the divider. A result that is still waiting holds
// the sequencer in its last step. A finished result sits in an output
// register while the next transaction is taken.
module pedal_swept_wah_biquad #(
  parameter int SAMPLE_BITS = psw_pkg::SampleBitsDef,
  parameter int COEF_BITS   = psw_pkg::CoefBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [psw_pkg::IdxBits-1:0]     cfg_idx_i,
  input  logic [psw_pkg::RegBits-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in_i,
  input  logic [psw_pkg::QBits-1:0]       pedal_position_i,
  input  logic                            block_end_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]   sample_out_o,
  output logic                            block_end_out_o
);
  import psw_pkg::*;
  `include "pedal_swept_wah_biquad_assert.svh"

  // multiplicand width (slope, coefs, y, x)
  localparam int MA = (COEF_BITS > 34) ? COEF_BITS : 34;
  localparam int MB = 34;              // multiplier width
  localparam int PW = MA + MB;
  localparam int NW = 64;              // dividend width
  localparam int DW = 34;

  // Configuration registers.
  logic signed [RegBits-1:0] b0_q, b1_q, b2_q, d0_q, d1_q, sl_q;
  logic [QBits-1:0] bal_q, pmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= '0; b1_q <= '0; b2_q <= '0;
      d0_q <= 32'sd268435456; d1_q <= '0; sl_q <= '0;
      bal_q <= OneQ16; pmax_q <= OneQ16;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_B0:    b0_q <= cfg_data_i;
        REG_B1:    b1_q <= cfg_data_i;
        REG_B2:    b2_q <= cfg_data_i;
        REG_D0:    d0_q <= cfg_data_i;
        REG_D1:    d1_q <= cfg_data_i;
        REG_SLOPE: sl_q <= cfg_data_i;
        REG_BAL:   bal_q <= cfg_data_i[QBits-1:0];
        REG_PMAX:  pmax_q <= cfg_data_i[QBits-1:0];
        default:   ;
      endcase
    end
  end

  // Datapath state.
  state_e st_q, st_d;
  logic [2:0] tap_q, tap_d;
  logic signed [SAMPLE_BITS-1:0] x_q, x1_q, x2_q;
  logic signed [31:0] y1_q, y2_q;
  logic [QBits-1:0] gp_q;
  logic blk_q;
  logic signed [COEF_BITS-1:0] a1_q, a2_q;
  logic signed [PW:0] acc_q;
  logic signed [31:0] y_q;
  logic out_v_q;
  logic signed [SAMPLE_BITS-1:0] out_s_q;
  logic out_b_q;

  unit_ctl_t mul_ctl, div_ctl;
  logic signed [MA-1:0] ma;
  logic signed [MB-1:0] mb;
  logic signed [PW-1:0] prod;
  logic signed [NW-1:0] dnum, quo;

  // Pedal term, lead term and derived numerators.
  logic signed [MA-1:0] term, n1, n2, a0_w;
  logic signed [PW-1:0] trm_w;

  psw_sermul #(.ABits(MA), .BBits(MB)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_ctl.start), .a_i(ma), .b_i(mb),
    .done_o(mul_ctl.done), .p_o(prod)
  );
  psw_serdiv #(.NBits(NW), .DBits(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_ctl.start), .num_i(dnum),
    .den_i(DW'(a0_w)), .done_o(div_ctl.done), .quo_o(quo)
  );

  // The pedal product stays in the multiplier until the taps start.
  assign trm_w = prod + PW'(32768);
  assign term  = MA'(trm_w >>> 16);
  assign a0_w  = MA'(d0_q) + term;
  assign n1 = MA'(d1_q) - (term <<< 1);
  assign n2 = MA'(34'sd536870912) - MA'(d0_q) + term;

  // Per-tap operands: coefficient and history value.
  logic signed [MA-1:0] tcoef;
  logic signed [MB-1:0] tval;
  always_comb begin
    case (tap_q)
      3'd0: begin tcoef = MA'(b0_q); tval = MB'(x_q);  end
      3'd1: begin tcoef = MA'(b1_q); tval = MB'(x1_q); end
      3'd2: begin tcoef = MA'(b2_q); tval = MB'(x2_q); end
      3'd3: begin tcoef = MA'(a1_q); tval = MB'(y1_q); end
      default: begin tcoef = MA'(a2_q); tval = MB'(y2_q); end
    endcase
  end

  // Saturation of the quotient to COEF_BITS.
  function automatic logic signed [COEF_BITS-1:0] sat_coef(logic signed [NW-1:0] v);
    logic signed [NW-1:0] hi, lo;
    hi = NW'({1'b0, {(COEF_BITS-1){1'b1}}});
    lo = ~hi;
    if (v > hi) return hi[COEF_BITS-1:0];
    if (v < lo) return lo[COEF_BITS-1:0];
    return v[COEF_BITS-1:0];
  endfunction

  // Filter output: fold in the last feedback tap, round and saturate.
  logic signed [PW:0] tap_p, ysum;
  logic signed [PW:0] yfl;
  logic signed [31:0] ysat;
  assign tap_p = (PW+1)'(prod >>> 16);
  assign ysum  = acc_q - tap_p + (PW+1)'(2048);
  assign yfl   = ysum >>> 12;
  assign ysat  = (yfl > (PW+1)'(32'sh7fffffff)) ? 32'sh7fffffff :
                 (yfl < -(PW+1)'(33'sh80000000)) ? 32'sh80000000 : yfl[31:0];

  logic [QBits-1:0] balc, pclamp;
  assign balc   = (bal_q > OneQ16) ? OneQ16 : bal_q;
  assign pclamp = (pedal_position_i > pmax_q) ? pmax_q : pedal_position_i;

  // Mix result saturation.
  logic signed [PW:0] msum, mfl;
  logic signed [SAMPLE_BITS-1:0] msat;
  localparam logic signed [PW:0] SHi = (PW+1)'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [PW:0] SLo = ~SHi;
  assign msum = acc_q + (PW+1)'(32768);
  assign mfl  = msum >>> 16;
  assign msat = (mfl > SHi) ? SHi[SAMPLE_BITS-1:0] :
                (mfl < SLo) ? SLo[SAMPLE_BITS-1:0] : mfl[SAMPLE_BITS-1:0];

  logic out_free;
  assign out_free   = !out_v_q || out_ready_i;
  assign in_ready_o = (st_q == ST_IDLE);

  // Sequencer: next state and unit operands.
  always_comb begin
    st_d = st_q;
    tap_d = tap_q;
    mul_ctl.start = 1'b0;
    div_ctl.start = 1'b0;
    ma = tcoef;
    mb = tval;
    dnum = NW'(n1) <<< 28;
    unique case (st_q)
      ST_IDLE: if (in_valid_i) begin
        st_d = ST_GAIN;
        mul_ctl.start = 1'b1;
        ma = MA'(sl_q);
        mb = MB'(((35'(pclamp) * 35'(GainQ16)) + 35'd32768) >> 16);
      end
      ST_GAIN: begin
        ma = MA'(sl_q);
        mb = MB'(gp_q);
        if (mul_ctl.done) begin
          if (a0_w == '0) begin
            st_d = ST_MAC;
            tap_d = 3'd0;
            mul_ctl.start = 1'b1;
            ma = MA'(b0_q);
            mb = MB'(x_q);
          end else begin
            st_d = ST_DIV1;
            div_ctl.start = 1'b1;
          end
        end
      end
      ST_DIV1: begin
        dnum = NW'(n2) <<< 28;
        if (div_ctl.done) begin
          st_d = ST_DIV2;
          div_ctl.start = 1'b1;
        end
      end
      ST_DIV2: if (div_ctl.done) begin
        st_d = ST_MAC;
        tap_d = 3'd0;
        mul_ctl.start = 1'b1;
        ma = MA'(b0_q);
        mb = MB'(x_q);
      end
      ST_MAC: if (mul_ctl.done) begin
        mul_ctl.start = 1'b1;
        if (tap_q == 3'd4) begin
          st_d = ST_MIX;
          tap_d = 3'd0;
          ma = MA'(ysat);
          mb = MB'(balc);
        end else begin
          tap_d = tap_q + 1'b1;
          unique case (tap_q)
            3'd0: begin ma = MA'(b1_q); mb = MB'(x1_q); end
            3'd1: begin ma = MA'(b2_q); mb = MB'(x2_q); end
            3'd2: begin ma = MA'(a1_q); mb = MB'(y1_q); end
            default: begin ma = MA'(a2_q); mb = MB'(y2_q); end
          endcase
        end
      end
      ST_MIX: if (mul_ctl.done) begin
        if (tap_q == 3'd0) begin
          mul_ctl.start = 1'b1;
          tap_d = 3'd1;
          ma = MA'(x_q);
          mb = MB'(OneQ16 - balc);
        end else begin
          st_d = ST_OUT;
        end
      end
      ST_OUT: if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      tap_q <= '0;
      out_v_q <= 1'b0;
      x1_q <= '0; x2_q <= '0; y1_q <= '0; y2_q <= '0;
    end else begin
      st_q <= st_d;
      tap_q <= tap_d;
      if (st_q == ST_OUT && out_free) begin
        out_v_q <= 1'b1;
        x2_q <= x1_q; x1_q <= x_q;
        y2_q <= y1_q; y1_q <= y_q;
      end else if (out_v_q && out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) begin
      x_q <= sample_in_i;
      blk_q <= block_end_i;
      gp_q <= QBits'(((35'(pclamp) * 35'(GainQ16)) + 35'd32768) >> 16);
      a1_q <= '0;
      a2_q <= '0;
    end
    if (st_q == ST_DIV1 && div_ctl.done) a1_q <= sat_coef(quo);
    if (st_q == ST_DIV2 && div_ctl.done) a2_q <= sat_coef(quo);
    // Clear, accumulate the taps, then accumulate the two mix products.
    if (st_q == ST_DIV2 || (st_q == ST_GAIN && mul_ctl.done)) begin
      acc_q <= '0;
    end else if (st_q == ST_MAC && mul_ctl.done) begin
      if (tap_q == 3'd4) acc_q <= '0;
      else if (tap_q == 3'd3) acc_q <= acc_q - tap_p;
      else acc_q <= acc_q + tap_p;
    end else if (st_q == ST_MIX && mul_ctl.done) begin
      acc_q <= acc_q + (PW+1)'(prod);
    end
    if (st_q == ST_MAC && mul_ctl.done && tap_q == 3'd4) y_q <= ysat;
    if (st_q == ST_OUT && out_free) begin
      out_s_q <= msat;
      out_b_q <= blk_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign sample_out_o    = out_s_q;
  assign block_end_out_o = out_b_q;

  // Checks on sequencing.
  `PSW_ASSERT_IMPL(a_one_unit, clk_i, rst_ni, mul_ctl.start, !div_ctl.start,
    "multiplier and divider started together")
  `PSW_ASSERT_NEXT(a_held_out, clk_i, rst_ni, out_v_q && !out_ready_i,
    out_v_q && $stable(out_s_q), "pending result changed")
  `PSW_ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, st_q != ST_IDLE, !in_ready_o,
    "input taken while busy")
endmodule

@@ bench/tb_pedal_swept_wah_biquad.sv @@
// Self-checking testbench for the pedal-swept wah biquad with a built-in predictor.
`timescale 1ns / 1ps
module tb_pedal_swept_wah_biquad;
  import psw_pkg::*;

  localparam int SW = SampleBitsDef;
  localparam int IdleLimit = 5000;
  localparam int SettleCycles = 450;
  localparam longint OneQ28 = 64'sd1 <<< 28;

  typedef enum int {CHK_ZERO, CHK_DRY, CHK_MODEL} chk_e;

  typedef struct {
    int              set;
    logic [SW-1:0]   sample;
    logic [16:0]     pedal;
    logic            blk_end;
    chk_e            chk;
  } row_t;

  typedef struct {
    logic [SW-1:0] sample;
    logic          blk_end;
  } mix_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [IdxBits-1:0] cfg_idx_i = '0;
  logic [RegBits-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [SW-1:0]     sample_in_i = '0;
  logic [QBits-1:0]  pedal_position_i = '0;
  logic              block_end_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [SW-1:0]     sample_out_o;
  logic              block_end_out_o;

  pedal_swept_wah_biquad DUT (.*);

  // Predictor copy of the registers and the delay lines
  longint num_b0, num_b1, num_b2, den_d0, den_d1, den_slope, wet_bal, ped_max;
  longint x_z1, x_z2, y_z1, y_z2;

  mix_t   mix_expected[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     quiet = 1'b0;
  int     ready_hold = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic longint clip(input longint v, input int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint tap(input longint c, input longint v);
    return (c * v) >>> 16;
  endfunction

  function automatic void reset_wah_model();
    num_b0 = 0; num_b1 = 0; num_b2 = 0;
    den_d0 = OneQ28; den_d1 = 0; den_slope = 0;
    wet_bal = 65536; ped_max = 65536;
    x_z1 = 0; x_z2 = 0; y_z1 = 0; y_z2 = 0;
  endfunction

  // Run one sample through the wah model and advance its delay lines
  function automatic logic [SW-1:0] wah_mix(input logic [SW-1:0] smp, input logic [16:0] pos);
    longint x, p, gp, term, a0, n1, n2, a1, a2, acc, y, bal;
    x = longint'($signed(smp));
    p = pos;
    if (p > ped_max) p = ped_max;
    gp = (p * 55706 + 32768) >>> 16;
    term = (gp * den_slope + 32768) >>> 16;
    a0 = den_d0 + term;
    n1 = den_d1 - 2 * term;
    n2 = 2 * OneQ28 - den_d0 + term;
    a1 = 0;
    a2 = 0;
    if (a0 != 0) begin
      a1 = clip((n1 * OneQ28) / a0, CoefBitsDef);
      a2 = clip((n2 * OneQ28) / a0, CoefBitsDef);
    end
    acc = tap(num_b0, x) + tap(num_b1, x_z1) + tap(num_b2, x_z2)
        - tap(a1, y_z1) - tap(a2, y_z2);
    y = clip((acc + 2048) >>> 12, 32);
    x_z2 = x_z1; x_z1 = x;
    y_z2 = y_z1; y_z1 = y;
    bal = (wet_bal > 65536) ? 65536 : wet_bal;
    return SW'(clip((bal * y + (65536 - bal) * x + 32768) >>> 16, SW));
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stalls on the result side
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready_i <= 1'b0;
    end else begin
      ready_hold = pick_gap();
      out_ready_i <= (ready_hold == 0);
      if (ready_hold > 0) ready_hold--;
    end
  end

  // Check results and watch for a hang, sampled mid-cycle
  always @(negedge clk_i) begin
    mix_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (mix_expected.size() == 0) begin
          report($sformatf("unexpected result sample=%0d", $signed(sample_out_o)));
        end else begin
          e = mix_expected.pop_front();
          if (sample_out_o !== e.sample)
            report($sformatf("sample_out %0d, want %0d", $signed(sample_out_o),
                             $signed(e.sample)));
          if (block_end_out_o !== e.blk_end)
            report($sformatf("block_end_out %b, want %b", block_end_out_o, e.blk_end));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("Timeout: no transaction for %0d cycles", IdleLimit);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Offer one sample; hold it until taken, then queue its expected mix
  task automatic send_sample(input logic [SW-1:0] smp, input logic [16:0] pos,
                             input logic be, input chk_e chk);
    mix_t e;
    logic [SW-1:0] model;
    int gap;
    in_valid_i       <= 1'b1;
    sample_in_i      <= smp;
    pedal_position_i <= pos;
    block_end_i      <= be;
    do @(negedge clk_i); while (!in_ready_o);
    model = wah_mix(smp, pos);
    e.blk_end = be;
    case (chk)
      CHK_ZERO: e.sample = '0;
      CHK_DRY:  e.sample = smp;
      default:  e.sample = model;
    endcase
    mix_expected.push_back(e);
    @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold off until every expected result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_idx_e'(i);
      cfg_data_i <= vals[i];
      case (reg_idx_e'(i))
        REG_B0:    num_b0 = longint'($signed(vals[i]));
        REG_B1:    num_b1 = longint'($signed(vals[i]));
        REG_B2:    num_b2 = longint'($signed(vals[i]));
        REG_D0:    den_d0 = longint'($signed(vals[i]));
        REG_D1:    den_d1 = longint'($signed(vals[i]));
        REG_SLOPE: den_slope = longint'($signed(vals[i]));
        REG_BAL:   wet_bal = vals[i][16:0];
        REG_PMAX:  ped_max = vals[i][16:0];
        default: ;
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] small_signed(input int unsigned mag);
    return $urandom_range(0, 1) ? 32'($urandom_range(0, mag))
                                : -32'($urandom_range(0, mag));
  endfunction

  // Random settings: mostly a plausible resonant filter, sometimes raw bits
  task automatic random_regs();
    logic [31:0] v[8];
    v[REG_B0]    = small_signed(1 << 26);
    v[REG_B1]    = small_signed(1 << 24);
    v[REG_B2]    = small_signed(1 << 26);
    v[REG_D0]    = 32'(OneQ28) + $urandom_range(0, 1 << 26);
    v[REG_D1]    = -32'($urandom_range(1 << 28, 1 << 29));
    v[REG_SLOPE] = small_signed(1 << 26);
    v[REG_BAL]   = $urandom_range(0, 131071);
    v[REG_PMAX]  = $urandom_range(0, 131071);
    for (int i = 0; i < 8; i++)
      if ($urandom_range(0, 5) == 0) v[i] = $urandom;
    if ($urandom_range(0, 2) == 0) v[REG_BAL] = 65536;
    write_regs(v);
  endtask

  logic [31:0] reg_sets[5][8] = '{
    '{32'd0, 32'd0, 32'd0, 32'h1000_0000, 32'd0, 32'd0, 32'd65536, 32'd65536},
    // dry only, pedal clamp at zero
    '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h1000_0000, 32'd0, 32'h7FFF_FFFF,
      32'd0, 32'd0},
    // resonant band pass swept by the pedal
    '{32'h00CC_CCCD, 32'd0, 32'hFF33_3333, 32'h1199_9999, 32'hE199_9999,
      32'hFD99_999A, 32'd49152, 32'd65536},
    // zero lead term, balance over one
    '{32'h0100_0000, 32'd0, 32'd0, 32'd0, 32'h1000_0000, 32'd0, 32'h1_FFFF, 32'h1_FFFF},
    // coefficient and filter overflow
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF,
      32'h8000_0000, 32'd65536, 32'd30000}
  };

  row_t stim_rows[] = '{
    '{0, 24'h7FFFFF, 17'd0,      1'b0, CHK_ZERO},
    '{0, 24'h800000, 17'd65536,  1'b1, CHK_ZERO},
    '{0, 24'h000000, 17'h1FFFF,  1'b0, CHK_ZERO},
    '{0, 24'h555555, 17'h0AAAA,  1'b1, CHK_ZERO},
    '{1, 24'h7FFFFF, 17'h1FFFF,  1'b1, CHK_DRY},
    '{1, 24'h800000, 17'd65536,  1'b0, CHK_DRY},
    '{1, 24'hAAAAAA, 17'h15555,  1'b1, CHK_DRY},
    '{1, 24'h000001, 17'd0,      1'b0, CHK_DRY},
    '{1, 24'hFFFFFF, 17'd1,      1'b1, CHK_DRY},
    '{2, 24'h400000, 17'd0,      1'b0, CHK_MODEL},
    '{2, 24'hC00000, 17'd32768,  1'b0, CHK_MODEL},
    '{2, 24'h7FFFFF, 17'd65536,  1'b1, CHK_MODEL},
    '{2, 24'h000000, 17'h1FFFF,  1'b0, CHK_MODEL},
    '{2, 24'h800000, 17'd65535,  1'b1, CHK_MODEL},
    '{3, 24'h7FFFFF, 17'd0,      1'b0, CHK_MODEL},
    '{3, 24'h800000, 17'h1FFFF,  1'b1, CHK_MODEL},
    '{3, 24'h123456, 17'd65536,  1'b0, CHK_MODEL},
    '{3, 24'hFEDCBA, 17'd100,    1'b1, CHK_MODEL},
    '{4, 24'h7FFFFF, 17'h1FFFF,  1'b0, CHK_MODEL},
    '{4, 24'h800000, 17'd0,      1'b1, CHK_MODEL},
    '{4, 24'h7FFFFF, 17'd29999,  1'b0, CHK_MODEL},
    '{4, 24'h800000, 17'd65536,  1'b1, CHK_MODEL},
    '{4, 24'h7FFFFF, 17'd30000,  1'b0, CHK_MODEL}
  };

  // Main sequence: directed table, then random phases under fresh settings
  initial begin
    int cur_set;
    reset_wah_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    cur_set = 0;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].set != cur_set) begin
        drain();
        cur_set = stim_rows[i].set;
        write_regs(reg_sets[cur_set]);
      end
      send_sample(stim_rows[i].sample, stim_rows[i].pedal, stim_rows[i].blk_end,
                  stim_rows[i].chk);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      random_regs();
      quiet = (ph == 0);
      for (int n = 0; n < 108; n++) begin
        if (ph == 1 && n == 50) drain();
        send_sample(SW'($urandom), 17'($urandom_range(0, 131071)),
                    1'($urandom), CHK_MODEL);
      end
    end

    in_valid_i <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/psw_pkg.sv
design/psw_sermul.sv
design/psw_serdiv.sv
design/pedal_swept_wah_biquad.sv
bench/tb_pedal_swept_wah_biquad.sv
